// ===== rtl/rpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared types and constants of the three-level radix page map unit.
// ----------------------------------------------------------------------------
package rpm_pkg;

   localparam int TOP_BITS_DEF   = 6;
   localparam int MID_BITS_DEF   = 6;
   localparam int LEAF_BITS_DEF  = 5;
   localparam int MID_NODES_DEF  = 16;
   localparam int LEAF_NODES_DEF = 64;
   localparam int VALUE_BITS_DEF = 48;

   localparam logic [2:0] KIND_MAP         = 3'd0;
   localparam logic [2:0] KIND_UNMAP       = 3'd1;
   localparam logic [2:0] KIND_GET         = 3'd2;
   localparam logic [2:0] KIND_MAP_RANGE   = 3'd3;
   localparam logic [2:0] KIND_UNMAP_RANGE = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ABSENT    = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [1:0] STATUS_ZERO      = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TOP,
      ST_MID,
      ST_LEAF,
      ST_EXEC,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/rpm_ram.sv =====
// ----------------------------------------------------------------------------
// rpm_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module rpm_ram #(
   parameter int AW = 4,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/three_level_radix_page_map_unit.sv =====
// ----------------------------------------------------------------------------
// Three-level radix page map unit
// One item at a time. A single-key item is accepted, then walks the dependent
// top, middle and leaf memory reads and the update, and presents its result
// once the response slot is free; a range item repeats the reads and the update for each key.
// After reset a clearing pass over max(MID_NODES*2^MID_BITS, LEAF_NODES*
// 2^LEAF_BITS) entries (2048 by default) runs before the first item is taken.
// ----------------------------------------------------------------------------
module three_level_radix_page_map_unit
   import rpm_pkg::*;
#(
   parameter int TOP_BITS   = TOP_BITS_DEF,
   parameter int MID_BITS   = MID_BITS_DEF,
   parameter int LEAF_BITS  = LEAF_BITS_DEF,
   parameter int MID_NODES  = MID_NODES_DEF,
   parameter int LEAF_NODES = LEAF_NODES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_kind,
   input  logic [TOP_BITS+MID_BITS+LEAF_BITS-1:0] req_key,
   input  logic [TOP_BITS+MID_BITS+LEAF_BITS:0]   req_key_end,
   input  logic [VALUE_BITS-1:0]                 req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [VALUE_BITS-1:0]                 rsp_read_value,
   output logic [1:0]                            rsp_status
);

   localparam int KEY_BITS     = TOP_BITS + MID_BITS + LEAF_BITS;
   localparam int TOP_SIZE     = 1 << TOP_BITS;
   localparam int MID_SIZE     = 1 << MID_BITS;
   localparam int LEAF_SIZE    = 1 << LEAF_BITS;
   localparam int MN_W         = (MID_NODES > 1) ? $clog2(MID_NODES) : 1;
   localparam int LN_W         = (LEAF_NODES > 1) ? $clog2(LEAF_NODES) : 1;
   localparam int MC_W         = $clog2(MID_SIZE + 1);
   localparam int LC_W         = $clog2(LEAF_SIZE + 1);
   localparam int MFC_W        = $clog2(MID_NODES + 1);
   localparam int LFC_W        = $clog2(LEAF_NODES + 1);
   localparam int MID_AW       = MN_W + MID_BITS;
   localparam int LEAF_AW      = LN_W + LEAF_BITS;
   localparam int MID_ENTRIES  = MID_NODES * MID_SIZE;
   localparam int LEAF_ENTRIES = LEAF_NODES * LEAF_SIZE;
   localparam int CLR_DEPTH    = (MID_ENTRIES > LEAF_ENTRIES) ? MID_ENTRIES : LEAF_ENTRIES;
   localparam int CW           = $clog2(CLR_DEPTH + 1);

   state_type                 state_ff, state_in;
   logic [2:0]                kind_ff, kind_in;
   logic [KEY_BITS-1:0]       cur_ff, cur_in;
   logic [KEY_BITS:0]         end_ff, end_in;
   logic [VALUE_BITS-1:0]     val_ff, val_in;
   logic [1:0]                st_ff, st_in;
   logic [VALUE_BITS-1:0]     rv_ff, rv_in;
   logic [CW-1:0]             clr_ff, clr_in;
   logic [TOP_SIZE-1:0]       top_valid_ff, top_valid_in;
   logic [MFC_W-1:0]          mfc_ff, mfc_in;
   logic [LFC_W-1:0]          lfc_ff, lfc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]     rsp_read_value_ff, rsp_read_value_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   logic [TOP_BITS-1:0]       t_idx;
   logic [MID_BITS-1:0]       m_idx;
   logic [LEAF_BITS-1:0]      l_idx;
   logic [KEY_BITS:0]         end_sat;
   logic [KEY_BITS:0]         cur_next;

   // Memory ports.
   logic                      top_we, mid_we, leaf_we, mcnt_we, lcnt_we, mfree_we, lfree_we;
   logic [TOP_BITS-1:0]       top_waddr;
   logic [MN_W-1:0]           top_wdata, top_rd;
   logic [MID_AW-1:0]         mid_waddr;
   logic [LN_W:0]             mid_wdata, mid_rd;
   logic [LEAF_AW-1:0]        leaf_waddr;
   logic [VALUE_BITS-1:0]     leaf_wdata, leaf_rd;
   logic [MN_W-1:0]           mcnt_waddr;
   logic [MC_W-1:0]           mcnt_wdata, mcnt_rd;
   logic [LN_W-1:0]           lcnt_waddr;
   logic [LC_W-1:0]           lcnt_wdata, lcnt_rd;
   logic [MN_W-1:0]           mfree_waddr, mfree_wdata, mfree_rd, mfree_raddr;
   logic [LN_W-1:0]           lfree_waddr, lfree_wdata, lfree_rd, lfree_raddr;

   // Decode of the current key's lookup.
   logic                      tv, mv, is_map, is_unmap, is_range;
   logic                      need_mid, need_leaf, exhausted, absent, last;
   logic [MN_W-1:0]           mn;
   logic [LN_W-1:0]           ln, ln_old;
   logic [VALUE_BITS-1:0]     old_val;
   logic [LC_W-1:0]           lc_dec;
   logic [MC_W-1:0]           mc_dec;
   logic [1:0]                st_key;

   assign t_idx    = cur_ff[KEY_BITS-1 -: TOP_BITS];
   assign m_idx    = cur_ff[LEAF_BITS +: MID_BITS];
   assign l_idx    = cur_ff[LEAF_BITS-1:0];
   assign end_sat  = req_key_end[KEY_BITS] ? {1'b1, {KEY_BITS{1'b0}}} : req_key_end;
   assign cur_next = {1'b0, cur_ff} + (KEY_BITS+1)'(1);

   assign mfree_raddr = MN_W'(mfc_ff - MFC_W'(1));
   assign lfree_raddr = LN_W'(lfc_ff - LFC_W'(1));

   assign tv        = top_valid_ff[t_idx];
   assign mv        = tv && mid_rd[LN_W];
   assign ln_old    = mid_rd[LN_W-1:0];
   assign is_map    = (kind_ff == KIND_MAP) || (kind_ff == KIND_MAP_RANGE);
   assign is_unmap  = (kind_ff == KIND_UNMAP) || (kind_ff == KIND_UNMAP_RANGE);
   assign is_range  = (kind_ff == KIND_MAP_RANGE) || (kind_ff == KIND_UNMAP_RANGE);
   assign need_mid  = !tv;
   assign need_leaf = !mv;
   assign exhausted = (need_mid && (mfc_ff == '0)) || (need_leaf && (lfc_ff == '0));
   assign mn        = need_mid ? mfree_rd : top_rd;
   assign ln        = need_leaf ? lfree_rd : ln_old;
   // A freshly taken leaf node holds only zero values.
   assign old_val   = need_leaf ? '0 : leaf_rd;
   assign absent    = !mv || (leaf_rd == '0);
   assign lc_dec    = (lcnt_rd != '0) ? lcnt_rd - LC_W'(1) : '0;
   assign mc_dec    = (mcnt_rd != '0) ? mcnt_rd - MC_W'(1) : '0;
   assign st_key    = (is_map && exhausted) ? STATUS_EXHAUSTED :
                      (is_unmap && absent) ? STATUS_ABSENT : STATUS_OK;
   assign last      = !is_range || (st_key != STATUS_OK) || (cur_next >= end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         top_valid_ff <= '0;
         mfc_ff       <= MFC_W'(MID_NODES);
         lfc_ff       <= LFC_W'(LEAF_NODES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_valid_ff <= top_valid_in;
         mfc_ff       <= mfc_in;
         lfc_ff       <= lfc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      cur_ff            <= cur_in;
      end_ff            <= end_in;
      val_ff            <= val_in;
      st_ff             <= st_in;
      rv_ff             <= rv_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   always_comb begin
      state_in          = state_ff;
      kind_in           = kind_ff;
      cur_in            = cur_ff;
      end_in            = end_ff;
      val_in            = val_ff;
      st_in             = st_ff;
      rv_in             = rv_ff;
      clr_in            = clr_ff;
      top_valid_in      = top_valid_ff;
      mfc_in            = mfc_ff;
      lfc_in            = lfc_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      req_ready         = 1'b0;

      top_we      = 1'b0;
      top_waddr   = t_idx;
      top_wdata   = mn;
      mid_we      = 1'b0;
      mid_waddr   = {mn, m_idx};
      mid_wdata   = {1'b1, ln};
      leaf_we     = 1'b0;
      leaf_waddr  = {ln, l_idx};
      leaf_wdata  = val_ff;
      mcnt_we     = 1'b0;
      mcnt_waddr  = mn;
      mcnt_wdata  = need_mid ? MC_W'(1) : mcnt_rd + MC_W'(1);
      lcnt_we     = 1'b0;
      lcnt_waddr  = ln;
      lcnt_wdata  = need_leaf ? LC_W'(1) : lcnt_rd + LC_W'(1);
      mfree_we    = 1'b0;
      mfree_waddr = MN_W'(mfc_ff);
      mfree_wdata = top_rd;
      lfree_we    = 1'b0;
      lfree_waddr = LN_W'(lfc_ff);
      lfree_wdata = ln_old;

      case (state_ff)
         ST_CLEAR: begin
            mid_waddr   = MID_AW'(clr_ff);
            mid_wdata   = '0;
            mid_we      = clr_ff < CW'(MID_ENTRIES);
            leaf_waddr  = LEAF_AW'(clr_ff);
            leaf_wdata  = '0;
            leaf_we     = clr_ff < CW'(LEAF_ENTRIES);
            mcnt_waddr  = MN_W'(clr_ff);
            mcnt_wdata  = '0;
            mcnt_we     = clr_ff < CW'(MID_NODES);
            lcnt_waddr  = LN_W'(clr_ff);
            lcnt_wdata  = '0;
            lcnt_we     = clr_ff < CW'(LEAF_NODES);
            // Free stacks hold the highest node at the bottom.
            mfree_waddr = MN_W'(clr_ff);
            mfree_wdata = MN_W'(MID_NODES - 1) - MN_W'(clr_ff);
            mfree_we    = clr_ff < CW'(MID_NODES);
            lfree_waddr = LN_W'(clr_ff);
            lfree_wdata = LN_W'(LEAF_NODES - 1) - LN_W'(clr_ff);
            lfree_we    = clr_ff < CW'(LEAF_NODES);
            clr_in      = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in = req_kind;
               cur_in  = req_key;
               end_in  = end_sat;
               val_in  = req_value;
               rv_in   = '0;
               st_in   = STATUS_OK;
               if (((req_kind == KIND_MAP) || (req_kind == KIND_MAP_RANGE)) &&
                   (req_value == '0)) begin
                  st_in    = STATUS_ZERO;
                  state_in = ST_DONE;
               end else if ((req_kind == KIND_MAP) || (req_kind == KIND_UNMAP) ||
                            (req_kind == KIND_GET)) begin
                  state_in = ST_TOP;
               end else if ((req_kind == KIND_MAP_RANGE) ||
                            (req_kind == KIND_UNMAP_RANGE)) begin
                  state_in = ({1'b0, req_key} >= end_sat) ? ST_DONE : ST_TOP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_TOP: begin
            state_in = ST_MID;
         end
         ST_MID: begin
            state_in = ST_LEAF;
         end
         ST_LEAF: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (is_map && !exhausted) begin
               if (need_mid) begin
                  top_we              = 1'b1;
                  top_valid_in[t_idx] = 1'b1;
                  mfc_in              = mfc_ff - MFC_W'(1);
               end
               if (need_leaf) begin
                  mid_we  = 1'b1;
                  mcnt_we = 1'b1;
                  lfc_in  = lfc_ff - LFC_W'(1);
               end
               lcnt_we = need_leaf || (old_val == '0);
               leaf_we = 1'b1;
            end else if (is_unmap && !absent) begin
               leaf_waddr = {ln_old, l_idx};
               leaf_wdata = '0;
               leaf_we    = 1'b1;
               lcnt_waddr = ln_old;
               lcnt_wdata = lc_dec;
               lcnt_we    = 1'b1;
               if (lc_dec == '0) begin
                  // The leaf node empties and goes back to its pool.
                  if (lfc_ff < LFC_W'(LEAF_NODES)) begin
                     lfree_we = 1'b1;
                     lfc_in   = lfc_ff + LFC_W'(1);
                  end
                  mid_waddr  = {top_rd, m_idx};
                  mid_wdata  = '0;
                  mid_we     = 1'b1;
                  mcnt_waddr = top_rd;
                  mcnt_wdata = mc_dec;
                  mcnt_we    = 1'b1;
                  if (mc_dec == '0) begin
                     if (mfc_ff < MFC_W'(MID_NODES)) begin
                        mfree_we = 1'b1;
                        mfc_in   = mfc_ff + MFC_W'(1);
                     end
                     top_valid_in[t_idx] = 1'b0;
                  end
               end
            end else if (kind_ff == KIND_GET) begin
               rv_in = mv ? leaf_rd : '0;
            end
            st_in = st_key;
            if (last) begin
               state_in = ST_DONE;
            end else begin
               cur_in   = cur_next[KEY_BITS-1:0];
               state_in = ST_TOP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = rv_ff;
               rsp_status_in     = st_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   rpm_ram #(.AW(TOP_BITS), .DW(MN_W)) u_top_ram (
      .clock(clock), .we(top_we), .waddr(top_waddr), .wdata(top_wdata),
      .re(state_ff == ST_TOP), .raddr(t_idx), .rdata(top_rd)
   );

   rpm_ram #(.AW(MID_AW), .DW(LN_W + 1)) u_mid_ram (
      .clock(clock), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
      .re(state_ff == ST_MID), .raddr({top_rd, m_idx}), .rdata(mid_rd)
   );

   rpm_ram #(.AW(LEAF_AW), .DW(VALUE_BITS)) u_leaf_ram (
      .clock(clock), .we(leaf_we), .waddr(leaf_waddr), .wdata(leaf_wdata),
      .re(state_ff == ST_LEAF), .raddr({ln_old, l_idx}), .rdata(leaf_rd)
   );

   rpm_ram #(.AW(MN_W), .DW(MC_W)) u_mcnt_ram (
      .clock(clock), .we(mcnt_we), .waddr(mcnt_waddr), .wdata(mcnt_wdata),
      .re(state_ff == ST_MID), .raddr(top_rd), .rdata(mcnt_rd)
   );

   rpm_ram #(.AW(LN_W), .DW(LC_W)) u_lcnt_ram (
      .clock(clock), .we(lcnt_we), .waddr(lcnt_waddr), .wdata(lcnt_wdata),
      .re(state_ff == ST_LEAF), .raddr(ln_old), .rdata(lcnt_rd)
   );

   rpm_ram #(.AW(MN_W), .DW(MN_W)) u_mfree_ram (
      .clock(clock), .we(mfree_we), .waddr(mfree_waddr), .wdata(mfree_wdata),
      .re(state_ff == ST_TOP), .raddr(mfree_raddr), .rdata(mfree_rd)
   );

   rpm_ram #(.AW(LN_W), .DW(LN_W)) u_lfree_ram (
      .clock(clock), .we(lfree_we), .waddr(lfree_waddr), .wdata(lfree_wdata),
      .re(state_ff == ST_TOP), .raddr(lfree_raddr), .rdata(lfree_rd)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in progress");

   a_mid_pool: assert property (@(posedge clock) disable iff (reset)
      mfc_ff <= MFC_W'(MID_NODES))
      else $error("middle free count beyond pool size");

   a_leaf_pool: assert property (@(posedge clock) disable iff (reset)
      lfc_ff <= LFC_W'(LEAF_NODES))
      else $error("leaf free count beyond pool size");
`endif

endmodule

// ===== sim/rpm_checker.sv =====
// ----------------------------------------------------------------------------
// Page map response checker
// Watches both channels of the radix page map unit. It keeps its own copy of
// the three-level map and works out the result of every accepted item. Each
// accepted result is then compared with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rpm_checker
   import rpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [16:0] req_key,
   input  logic [17:0] req_key_end,
   input  logic [47:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [47:0] rsp_read_value,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_TOP   = 64;
   localparam int N_MID   = MID_NODES_DEF;
   localparam int N_LEAF  = LEAF_NODES_DEF;
   localparam int MID_SZ  = 64;
   localparam int LEAF_SZ = 32;
   localparam int KEY_TOP = 131072;

   typedef struct packed {
      logic [47:0] read_value;
      logic [1:0]  status;
   } page_result_type;

   bit          top_live [N_TOP];
   logic [3:0]  top_node [N_TOP];
   bit          mid_live [N_MID*MID_SZ];
   logic [5:0]  mid_leaf [N_MID*MID_SZ];
   logic [47:0] leaf_val [N_LEAF*LEAF_SZ];
   int          mid_used [N_MID];
   int          leaf_used [N_LEAF];
   int          mid_stack [N_MID];
   int          mid_avail;
   int          leaf_stack [N_LEAF];
   int          leaf_avail;

   page_result_type awaited_results[$];

   function automatic logic [47:0] walk_lookup(int k);
      int t;
      int mi;
      t = k >> 11;
      if (!top_live[t]) return 48'd0;
      mi = top_node[t] * MID_SZ + ((k >> 5) & 63);
      if (!mid_live[mi]) return 48'd0;
      return leaf_val[mid_leaf[mi] * LEAF_SZ + (k & 31)];
   endfunction

   function automatic logic [1:0] install_page(int k, logic [47:0] v);
      int t;
      int mi;
      int mn;
      int ln;
      int li;
      bit need_mid;
      bit need_leaf;
      t = k >> 11;
      mi = 0;
      need_mid = !top_live[t];
      need_leaf = need_mid;
      if (!need_mid) begin
         mi = top_node[t] * MID_SZ + ((k >> 5) & 63);
         need_leaf = !mid_live[mi];
      end
      if (need_mid && mid_avail == 0) return STATUS_EXHAUSTED;
      if (need_leaf && leaf_avail == 0) return STATUS_EXHAUSTED;
      if (need_mid) begin
         mid_avail--;
         mn = mid_stack[mid_avail];
         top_node[t] = 4'(mn);
         top_live[t] = 1;
         mid_used[mn] = 0;
         mi = mn * MID_SZ + ((k >> 5) & 63);
      end
      if (need_leaf) begin
         leaf_avail--;
         ln = leaf_stack[leaf_avail];
         mid_leaf[mi] = 6'(ln);
         mid_live[mi] = 1;
         mid_used[top_node[t]]++;
         leaf_used[ln] = 0;
      end
      ln = mid_leaf[mi];
      li = ln * LEAF_SZ + (k & 31);
      if (leaf_val[li] == '0) leaf_used[ln]++;
      leaf_val[li] = v;
      return STATUS_OK;
   endfunction

   function automatic logic [1:0] remove_page(int k);
      int t;
      int mi;
      int mn;
      int ln;
      int li;
      t = k >> 11;
      if (!top_live[t]) return STATUS_ABSENT;
      mn = top_node[t];
      mi = mn * MID_SZ + ((k >> 5) & 63);
      if (!mid_live[mi]) return STATUS_ABSENT;
      ln = mid_leaf[mi];
      li = ln * LEAF_SZ + (k & 31);
      if (leaf_val[li] == '0) return STATUS_ABSENT;
      leaf_val[li] = '0;
      if (leaf_used[ln] > 0) leaf_used[ln]--;
      if (leaf_used[ln] == 0) begin
         if (leaf_avail < N_LEAF) begin
            leaf_stack[leaf_avail] = ln;
            leaf_avail++;
         end
         mid_live[mi] = 0;
         mid_leaf[mi] = '0;
         if (mid_used[mn] > 0) mid_used[mn]--;
         if (mid_used[mn] == 0) begin
            if (mid_avail < N_MID) begin
               mid_stack[mid_avail] = mn;
               mid_avail++;
            end
            top_live[t] = 0;
            top_node[t] = '0;
         end
      end
      return STATUS_OK;
   endfunction

   function automatic page_result_type page_map_outcome(logic [2:0] kind, logic [16:0] key,
                                                        logic [17:0] kend, logic [47:0] v);
      page_result_type r;
      int stop;
      int c;
      r.read_value = 48'd0;
      r.status = STATUS_OK;
      stop = (kend > KEY_TOP) ? KEY_TOP : int'(kend);
      case (kind)
         KIND_MAP: begin
            r.status = (v == '0) ? STATUS_ZERO : install_page(int'(key), v);
         end
         KIND_UNMAP: begin
            r.status = remove_page(int'(key));
         end
         KIND_GET: begin
            r.read_value = walk_lookup(int'(key));
         end
         KIND_MAP_RANGE, KIND_UNMAP_RANGE: begin
            if (kind == KIND_MAP_RANGE && v == '0) begin
               r.status = STATUS_ZERO;
            end else begin
               // A range gives up at the first key that fails and keeps the rest.
               for (c = int'(key); c < stop; c++) begin
                  r.status = (kind == KIND_MAP_RANGE) ? install_page(c, v) : remove_page(c);
                  if (r.status != STATUS_OK) break;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      for (int i = 0; i < N_TOP; i++) begin
         top_live[i] = 0;
         top_node[i] = '0;
      end
      for (int i = 0; i < N_MID*MID_SZ; i++) begin
         mid_live[i] = 0;
         mid_leaf[i] = '0;
      end
      for (int i = 0; i < N_LEAF*LEAF_SZ; i++) leaf_val[i] = '0;
      for (int i = 0; i < N_MID; i++) begin
         mid_used[i] = 0;
         mid_stack[i] = N_MID - 1 - i;
      end
      for (int i = 0; i < N_LEAF; i++) begin
         leaf_used[i] = 0;
         leaf_stack[i] = N_LEAF - 1 - i;
      end
      mid_avail = N_MID;
      leaf_avail = N_LEAF;
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      page_result_type exp_r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(page_map_outcome(req_kind, req_key, req_key_end,
                                                       req_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result read_value=%h status=%0d", $realtime,
                        rsp_read_value, rsp_status);
               fail_count++;
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_read_value !== exp_r.read_value) begin
                  $display("%0t: read_value expected %h actual %h", $realtime,
                           exp_r.read_value, rsp_read_value);
                  fail_count++;
               end
               if (rsp_status !== exp_r.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           exp_r.status, rsp_status);
                  fail_count++;
               end
            end
         end
         pending = awaited_results.size();
      end
   end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Radix page map unit testbench
// Drives directed and random map, unmap, get and range items into the unit
// under varying idle patterns on both channels, with one long result stall,
// and gives the verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module testbench
   import rpm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 20000000;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [2:0]  kind;
      logic [16:0] key;
      logic [17:0] kend;
      logic [47:0] value;
   } page_req_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [16:0] req_key = '0;
   logic [17:0] req_key_end = '0;
   logic [47:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [47:0] rsp_read_value;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          pending;

   page_req_type directed_items[$];
   int          total_items;
   int          sent = 0;
   int          phase = 0;
   int          cycles = 0;
   int          hold_left = 0;
   bit          hold_done = 0;

   three_level_radix_page_map_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_key(req_key), .req_key_end(req_key_end), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_status(rsp_status)
   );

   rpm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_key(req_key), .req_key_end(req_key_end), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_status(rsp_status),
      .fail_count(fail_count), .pending(pending)
   );

   always #1 clock = ~clock;

   function automatic page_req_type make_req(logic [2:0] kind, logic [16:0] key,
                                             logic [17:0] kend, logic [47:0] value);
      page_req_type r;
      r.kind = kind;
      r.key = key;
      r.kend = kend;
      r.value = value;
      return r;
   endfunction

   // Most keys fall in a hot window of twenty top entries and four middle
   // entries, enough to run both node pools dry and to hit mapped keys often.
   function automatic page_req_type random_req();
      page_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) r.kind = KIND_MAP;
      else if (pick < 50) r.kind = KIND_UNMAP;
      else if (pick < 70) r.kind = KIND_GET;
      else if (pick < 82) r.kind = KIND_MAP_RANGE;
      else if (pick < 94) r.kind = KIND_UNMAP_RANGE;
      else r.kind = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 75)
         r.key = {6'($urandom_range(0, 19)), 6'($urandom_range(0, 3)), 5'($urandom)};
      else
         r.key = 17'($urandom);
      if ($urandom_range(0, 99) < 4) r.kend = 18'($urandom);
      else r.kend = 18'(r.key) + 18'($urandom_range(0, 40));
      r.value = ($urandom_range(0, 99) < 5) ? 48'd0 : {16'($urandom), 32'($urandom)};
      return r;
   endfunction

   initial begin
      directed_items.push_back(make_req(KIND_MAP, 17'd0, 18'd0, {48{1'b1}}));
      directed_items.push_back(make_req(KIND_GET, 17'd0, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_MAP, 17'd0, 18'd0, 48'h5a5a_a5a5_0f0f));
      directed_items.push_back(make_req(KIND_GET, 17'd0, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_MAP, 17'd1, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_UNMAP, 17'd2, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_UNMAP, 17'd0, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_GET, 17'd0, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_MAP, {17{1'b1}}, {18{1'b1}}, 48'd1));
      directed_items.push_back(make_req(KIND_GET, {17{1'b1}}, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_MAP_RANGE, 17'd100, 18'd50, 48'd7));
      directed_items.push_back(make_req(KIND_MAP_RANGE, 17'd100, 18'd100, 48'd0));
      directed_items.push_back(make_req(KIND_MAP_RANGE, 17'd131060, {18{1'b1}}, 48'd9));
      directed_items.push_back(make_req(KIND_UNMAP_RANGE, 17'd131060, {18{1'b1}}, 48'd0));
      directed_items.push_back(make_req(3'd5, {17{1'b1}}, {18{1'b1}}, {48{1'b1}}));
      directed_items.push_back(make_req(3'd6, 17'd3, 18'd9, 48'd3));
      directed_items.push_back(make_req(3'd7, 17'd0, 18'd0, 48'd0));
      directed_items.push_back(make_req(KIND_GET, 17'd77777, 18'd0, 48'd0));
      // Filling the whole key space stops when the leaf pool runs dry.
      directed_items.push_back(make_req(KIND_MAP_RANGE, 17'd0, 18'd131072, 48'hbeef));
      directed_items.push_back(make_req(KIND_UNMAP_RANGE, 17'd0, 18'd131072, 48'd0));
      // Seventeen top entries need more middle nodes than the pool holds.
      for (int i = 0; i < 17; i++)
         directed_items.push_back(make_req(KIND_MAP, 17'(i << 11), 18'd0, 48'd1));
      for (int i = 0; i < 17; i++)
         directed_items.push_back(make_req(KIND_UNMAP, 17'(i << 11), 18'd0, 48'd0));
      total_items = directed_items.size() + RANDOM_ITEMS;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == 7) reset <= 0;
      if (cycles > CYCLE_LIMIT) begin
         $display("three_level_radix_page_map_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      page_req_type item;
      bit idle;
      if (!reset && (!req_valid || req_ready)) begin
         phase = (sent < total_items / 3) ? 0 : (sent < 2 * total_items / 3) ? 1 : 2;
         idle = (phase == 0) ? ($urandom_range(0, 99) < 22) :
                (phase == 1) ? ($urandom_range(0, 99) < 77) : 1'b0;
         if (sent < total_items && !idle) begin
            item = (sent < directed_items.size()) ? directed_items[sent] : random_req();
            req_valid <= 1;
            req_kind <= item.kind;
            req_key <= item.key;
            req_key_end <= item.kend;
            req_value <= item.value;
            sent++;
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (phase == 2 && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (phase == 0) begin
         rsp_ready <= ($urandom_range(0, 99) >= 77);
      end else if (phase == 1) begin
         rsp_ready <= ($urandom_range(0, 99) >= 22);
      end else begin
         rsp_ready <= 1;
      end
   end

   initial begin
      @(posedge clock);
      while (reset || sent < total_items || req_valid) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("three_level_radix_page_map_unit: match");
      end else begin
         $display("three_level_radix_page_map_unit: mismatch");
      end
      $finish;
   end

endmodule
